// ----- rtl/pmi_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pmi_pkg
// Shared types, command codes and constants of the 2D point mass integrator.
// ----------------------------------------------------------------------------
package pmi_pkg;

   localparam logic [1:0] CMD_THRUST = 2'd0;
   localparam logic [1:0] CMD_STEP   = 2'd1;
   localparam logic [1:0] CMD_STOP   = 2'd2;
   localparam logic [1:0] CMD_LOAD   = 2'd3;

   localparam int         CSR_IDX_W    = 3;
   localparam logic [2:0] REG_MASS     = 3'd0;
   localparam logic [2:0] REG_GRAVITY  = 3'd1;
   localparam logic [2:0] REG_FRICTION = 3'd2;
   localparam logic [2:0] REG_DT       = 3'd3;

   localparam logic [30:0] MASS_RST = 31'd65536;
   localparam logic [31:0] GRAV_RST = 32'd65536;
   localparam logic [16:0] DT_RST   = 17'd1049;

   localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] S32_MIN = 32'sh80000000;

   // datapath operations, one per controller step
   localparam logic [3:0] OP_NONE   = 4'd0;
   localparam logic [3:0] OP_WEIGHT = 4'd1;  // weight, force sums
   localparam logic [3:0] OP_DIVX   = 4'd2;  // start divide x
   localparam logic [3:0] OP_DIVY   = 4'd3;  // start divide y
   localparam logic [3:0] OP_VX     = 4'd4;
   localparam logic [3:0] OP_VY     = 4'd5;
   localparam logic [3:0] OP_DT2    = 4'd6;
   localparam logic [3:0] OP_FRIC   = 4'd7;
   localparam logic [3:0] OP_PVX    = 4'd8;
   localparam logic [3:0] OP_PVY    = 4'd9;
   localparam logic [3:0] OP_PAX    = 4'd10;
   localparam logic [3:0] OP_PAY    = 4'd11;
   localparam logic [3:0] OP_FINISH = 4'd12;

   typedef struct packed {
      logic       load_item;
      logic [1:0] command;
      logic [3:0] op;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
   } status_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
      if (x > 66'sd2147483647)       return S32_MAX;
      else if (x < -66'sd2147483648) return S32_MIN;
      else                           return x[31:0];
   endfunction

endpackage
`default_nettype wire

// ----- rtl/pmi_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pmi_req_if / pmi_rsp_if
// Valid/ready channels of the point mass integrator.
// ----------------------------------------------------------------------------
interface pmi_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         command;
   logic signed [31:0] value_x;
   logic signed [31:0] value_y;
   logic               grounded;
   modport source (output valid, command, value_x, value_y, grounded, input ready);
   modport sink   (input valid, command, value_x, value_y, grounded, output ready);
endinterface

interface pmi_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] position_x;
   logic signed [31:0] position_y;
   logic signed [31:0] velocity_x;
   logic signed [31:0] velocity_y;
   modport source (output valid, position_x, position_y, velocity_x, velocity_y,
                   input ready);
   modport sink   (input valid, position_x, position_y, velocity_x, velocity_y,
                   output ready);
endinterface
`default_nettype wire

// ----- rtl/pmi_divider.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pmi_divider
// Restoring signed divider, one quotient bit a cycle, truncation toward zero,
// saturated to 32 bits. Dividend is force * 2^16 (48 bits).
// ----------------------------------------------------------------------------
module pmi_divider (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [31:0] force_val,
   input  wire logic signed [31:0] weight,
   output logic                    busy,
   output logic signed [31:0]      quotient
);
   logic [47:0] rem_ff, rem_in;
   logic [47:0] quo_ff, quo_in;
   logic [31:0] den_ff, den_in;
   logic        neg_ff, neg_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [48:0] trial;
   logic [47:0] shifted;
   logic [48:0] mag;
   logic signed [49:0] sq;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      shifted = {rem_ff[46:0], quo_ff[47]};
      trial   = {1'b0, shifted} - {17'd0, den_ff};
      if (start) begin
         rem_in  = '0;
         quo_in  = force_val[31] ? 48'(-{force_val, 16'd0}) : {force_val, 16'd0};
         den_in  = weight[31] ? 32'(-weight) : weight;
         neg_in  = force_val[31] ^ weight[31];
         cnt_in  = 6'd48;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[48]) rem_in = trial[47:0];
         else            rem_in = shifted;
         quo_in = {quo_ff[46:0], ~trial[48]};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign mag      = {1'b0, quo_ff};
   assign sq       = neg_ff ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   assign quotient = pmi_pkg::sat32(66'(sq));
   assign busy     = busy_ff;
endmodule
`default_nettype wire

// ----- rtl/pmi_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pmi_datapath
// State registers, one shared 33x33 multiplier with registered product, and
// the divider. Each controller op does a multiply, an accumulate or a divide.
// ----------------------------------------------------------------------------
module pmi_datapath (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire pmi_pkg::cmd_type   cmd,
   output pmi_pkg::status_type     status,
   input  wire logic signed [31:0] value_x,
   input  wire logic signed [31:0] value_y,
   input  wire logic               grounded,
   input  wire logic [30:0]        body_mass,
   input  wire logic signed [31:0] gravity_value,
   input  wire logic [30:0]        friction_coefficient,
   input  wire logic [16:0]        time_step,
   output logic signed [31:0]      position_x,
   output logic signed [31:0]      position_y,
   output logic signed [31:0]      velocity_x,
   output logic signed [31:0]      velocity_y
);
   logic signed [31:0] tsx_ff, tsx_in, tsy_ff, tsy_in;
   logic signed [31:0] cfx_ff, cfx_in, cfy_ff, cfy_in;
   logic signed [31:0] vx_ff, vx_in, vy_ff, vy_in;
   logic signed [31:0] px_ff, px_in, py_ff, py_in;
   logic signed [31:0] fx_ff, fx_in, fy_ff, fy_in;
   logic signed [31:0] w_ff, w_in, ax_ff, ax_in, ay_ff, ay_in;
   logic signed [31:0] dt2_ff, dt2_in;
   logic signed [65:0] acc_ff, acc_in;   // position partial sum
   logic               gnd_ff, gnd_in;
   logic signed [32:0] ma, mb;
   logic signed [65:0] prod;
   logic signed [65:0] wprod_ff, wprod_in;
   logic               div_start, div_busy;
   logic signed [31:0] div_n, div_q;
   logic signed [31:0] wsat;
   logic signed [65:0] sh16, sh17;
   logic [3:0]         op;

   assign op = cmd.op;

   pmi_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .force_val(div_n),
      .weight(w_ff), .busy(div_busy), .quotient(div_q)
   );

   // multiplier operand select: the product is registered in wprod_ff and used when pop_ff holds the op
   always_comb begin
      ma = '0;
      mb = '0;
      unique case (op)
         pmi_pkg::OP_WEIGHT: begin ma = {2'b0, body_mass}; mb = 33'(gravity_value); end
         pmi_pkg::OP_VX:     begin ma = 33'(div_q); mb = {16'd0, time_step}; end
         pmi_pkg::OP_VY:     begin ma = 33'(div_q); mb = {16'd0, time_step}; end
         pmi_pkg::OP_DT2:    begin ma = {16'd0, time_step}; mb = {16'd0, time_step}; end
         pmi_pkg::OP_FRIC:   begin ma = 33'(vx_ff); mb = {2'b0, friction_coefficient}; end
         pmi_pkg::OP_PVX:    begin ma = 33'(vx_ff); mb = {16'd0, time_step}; end
         pmi_pkg::OP_PVY:    begin ma = 33'(vy_ff); mb = {16'd0, time_step}; end
         pmi_pkg::OP_PAX:    begin ma = 33'(ax_ff); mb = 33'(dt2_ff); end
         pmi_pkg::OP_PAY:    begin ma = 33'(ay_ff); mb = 33'(dt2_ff); end
         default: ;
      endcase
   end

   assign prod = ma * mb;
   assign sh16 = wprod_ff >>> 16;
   assign sh17 = wprod_ff >>> 17;
   assign wsat = pmi_pkg::sat32(sh16);
   assign div_start = (op == pmi_pkg::OP_DIVX) || (op == pmi_pkg::OP_DIVY);
   assign div_n     = (op == pmi_pkg::OP_DIVY) ? fy_ff : fx_ff;

   // the previous op's product arrives in wprod_ff; prev op held in pop_ff
   logic [3:0] pop_ff;

   always_comb begin
      tsx_in = tsx_ff; tsy_in = tsy_ff; cfx_in = cfx_ff; cfy_in = cfy_ff;
      vx_in = vx_ff; vy_in = vy_ff; px_in = px_ff; py_in = py_ff;
      fx_in = fx_ff; fy_in = fy_ff; w_in = w_ff; ax_in = ax_ff; ay_in = ay_ff;
      dt2_in = dt2_ff; acc_in = acc_ff; gnd_in = gnd_ff;
      wprod_in = prod;
      if (cmd.load_item) begin
         gnd_in = grounded;
         unique case (cmd.command)
            pmi_pkg::CMD_THRUST: begin
               tsx_in = pmi_pkg::sat32(66'(tsx_ff) + 66'(value_x));
               tsy_in = pmi_pkg::sat32(66'(tsy_ff) + 66'(value_y));
            end
            pmi_pkg::CMD_STOP: begin
               tsx_in = '0; tsy_in = '0; cfx_in = '0; cfy_in = '0;
               vx_in = '0; vy_in = '0;
            end
            pmi_pkg::CMD_LOAD: begin
               px_in = value_x; py_in = value_y;
            end
            default: ;
         endcase
      end
      // results of the op issued last cycle
      case (pop_ff)
         pmi_pkg::OP_WEIGHT: begin
            w_in  = wsat;
            fx_in = pmi_pkg::sat32(66'(cfx_ff) + 66'(tsx_ff));
            fy_in = pmi_pkg::sat32(66'(cfy_ff) + 66'(tsy_ff));
         end
         pmi_pkg::OP_VX: begin
            ax_in = (w_ff == 0) ? 32'sd0 : div_q;
            vx_in = (w_ff == 0) ? vx_ff : pmi_pkg::sat32(66'(vx_ff) + sh16);
         end
         pmi_pkg::OP_VY: begin
            ay_in = (w_ff == 0) ? 32'sd0 : div_q;
            vy_in = (w_ff == 0) ? vy_ff : pmi_pkg::sat32(66'(vy_ff) + sh16);
            tsx_in = '0; tsy_in = '0;
            if (gnd_ff) vy_in = '0;
         end
         pmi_pkg::OP_DT2: dt2_in = sh16[31:0];
         pmi_pkg::OP_FRIC: begin
            if (gnd_ff) begin
               cfx_in = pmi_pkg::sat32((-wprod_ff) >>> 16);
               cfy_in = '0;
            end else begin
               cfx_in = '0;
               cfy_in = w_ff;
            end
         end
         pmi_pkg::OP_PVX: acc_in = 66'(px_ff) + sh16;
         pmi_pkg::OP_PVY: begin
            px_in  = 32'(acc_ff[31:0]);
            acc_in = 66'(py_ff) + sh16;
            fx_in  = 32'(acc_ff >>> 32);
            fy_in  = 32'(acc_ff[31:0]);
         end
         pmi_pkg::OP_PAX: begin
            acc_in = acc_ff;
            px_in  = pmi_pkg::sat32(66'($signed({fx_ff, fy_ff})) + 66'(sh17));
         end
         pmi_pkg::OP_PAY: begin
            py_in = pmi_pkg::sat32(acc_ff + sh17);
         end
         default: ;
      endcase
   end
   // note: {fx,fy} holds the x partial sum (34 bits max) between PVY and PAX

   always_ff @(posedge clock) begin
      if (reset) begin
         tsx_ff <= '0; tsy_ff <= '0; cfx_ff <= '0; cfy_ff <= '0;
         vx_ff <= '0; vy_ff <= '0; px_ff <= '0; py_ff <= '0;
         pop_ff <= pmi_pkg::OP_NONE;
      end else begin
         tsx_ff <= tsx_in; tsy_ff <= tsy_in; cfx_ff <= cfx_in; cfy_ff <= cfy_in;
         vx_ff <= vx_in; vy_ff <= vy_in; px_ff <= px_in; py_ff <= py_in;
         pop_ff <= op;
      end
      fx_ff <= fx_in; fy_ff <= fy_in; w_ff <= w_in;
      ax_ff <= ax_in; ay_ff <= ay_in; dt2_ff <= dt2_in;
      acc_ff <= acc_in; gnd_ff <= gnd_in; wprod_ff <= wprod_in;
   end

   // VX/VY ops multiply div_q; the controller issues them when the quotient
   // of the matching divide is ready, and ax/ay are zeroed via weight check.
   assign status.div_busy = div_busy;
   assign position_x = px_ff;
   assign position_y = py_ff;
   assign velocity_x = vx_ff;
   assign velocity_y = vy_ff;
endmodule
`default_nettype wire

// ----- rtl/pmi_controller.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pmi_controller
// Sequences a step: weight, divide x, velocity x, divide y, velocity y, dt^2,
// friction, position terms, then holds the result word until taken.
// ----------------------------------------------------------------------------
module pmi_controller (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [1:0]          req_command,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output pmi_pkg::cmd_type         cmd,
   input  wire pmi_pkg::status_type status
);
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_WGT  = 4'd1;
   localparam logic [3:0] S_DX   = 4'd2;
   localparam logic [3:0] S_WX   = 4'd3;
   localparam logic [3:0] S_VX   = 4'd4;
   localparam logic [3:0] S_DY   = 4'd5;
   localparam logic [3:0] S_WY   = 4'd6;
   localparam logic [3:0] S_VY   = 4'd7;
   localparam logic [3:0] S_DT2  = 4'd8;
   localparam logic [3:0] S_FR   = 4'd9;
   localparam logic [3:0] S_PVX  = 4'd10;
   localparam logic [3:0] S_PVY  = 4'd11;
   localparam logic [3:0] S_PAX  = 4'd12;
   localparam logic [3:0] S_PAY  = 4'd13;
   localparam logic [3:0] S_FIN  = 4'd14;
   localparam logic [3:0] S_OUT  = 4'd15;

   logic [3:0] state_ff, state_in;
   logic       accept;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in      = state_ff;
      cmd.load_item = accept;
      cmd.command   = req_command;
      cmd.op        = pmi_pkg::OP_NONE;
      unique case (state_ff)
         S_IDLE: if (accept && req_command == pmi_pkg::CMD_STEP) state_in = S_WGT;
         S_WGT: begin cmd.op = pmi_pkg::OP_WEIGHT; state_in = S_DX; end
         S_DX:  begin cmd.op = pmi_pkg::OP_NONE; state_in = S_WX; end
         S_WX:  begin cmd.op = pmi_pkg::OP_DIVX; state_in = S_VX; end
         S_VX:  if (!status.div_busy) begin cmd.op = pmi_pkg::OP_VX; state_in = S_DY; end
         S_DY:  begin cmd.op = pmi_pkg::OP_NONE; state_in = S_WY; end
         S_WY:  begin cmd.op = pmi_pkg::OP_DIVY; state_in = S_VY; end
         S_VY:  if (!status.div_busy) begin cmd.op = pmi_pkg::OP_VY; state_in = S_DT2; end
         S_DT2: begin cmd.op = pmi_pkg::OP_DT2; state_in = S_FR; end
         S_FR:  begin cmd.op = pmi_pkg::OP_FRIC; state_in = S_PVX; end
         S_PVX: begin cmd.op = pmi_pkg::OP_PVX; state_in = S_PVY; end
         S_PVY: begin cmd.op = pmi_pkg::OP_PVY; state_in = S_PAX; end
         S_PAX: begin cmd.op = pmi_pkg::OP_PAX; state_in = S_PAY; end
         S_PAY: begin cmd.op = pmi_pkg::OP_PAY; state_in = S_FIN; end
         S_FIN: begin cmd.op = pmi_pkg::OP_FINISH; state_in = S_OUT; end
         S_OUT: if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end
endmodule
`default_nettype wire

// ----- rtl/point_mass_integrator_2d.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// point_mass_integrator_2d
// Euler integrator for one 2D point mass in signed Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   req channel takes one word: command, value_x, value_y, grounded.
//   Thrust, stop and load commands take effect on accept and give no result.
//   A step command returns one rsp word with new position and velocity.
//   A step runs from accept to rsp_valid through two divisions in the shared
//   bit-serial divider, x then y, and sequencing around the shared multiplier.
//   One item at a time; after a step the next word can be taken in the cycle
//   after the rsp handshake.
//   The rsp word is held in the state registers while rsp_ready is low;
//   no new word is accepted until it is taken.
//   csr port writes mass, gravity, friction and dt (index 0..3); the user must
//   write only while idle (not enforced here); other indexes are ignored.
//   Synchronous reset clears the state and loads the register defaults.
// ----------------------------------------------------------------------------
module point_mass_integrator_2d (
   input  wire logic                               clock,
   input  wire logic                               reset,
   pmi_req_if.sink                                 req,
   pmi_rsp_if.source                               rsp,
   input  wire logic                               csr_write_enable,
   input  wire logic [pmi_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [31:0]                        csr_write_data
);
   logic [30:0] mass_ff;
   logic [31:0] grav_ff;
   logic [30:0] fric_ff;
   logic [16:0] dt_ff;
   pmi_pkg::cmd_type    cmd;
   pmi_pkg::status_type status;

   always_ff @(posedge clock) begin
      if (reset) begin
         mass_ff <= pmi_pkg::MASS_RST;
         grav_ff <= pmi_pkg::GRAV_RST;
         fric_ff <= '0;
         dt_ff   <= pmi_pkg::DT_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            pmi_pkg::REG_MASS:     mass_ff <= csr_write_data[30:0];
            pmi_pkg::REG_GRAVITY:  grav_ff <= csr_write_data;
            pmi_pkg::REG_FRICTION: fric_ff <= csr_write_data[30:0];
            pmi_pkg::REG_DT:       dt_ff   <= csr_write_data[16:0];
            default: ;
         endcase
      end
   end

   pmi_controller u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready), .req_command(req.command),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .cmd(cmd), .status(status)
   );

   pmi_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .value_x(req.value_x), .value_y(req.value_y), .grounded(req.grounded),
      .body_mass(mass_ff), .gravity_value($signed(grav_ff)),
      .friction_coefficient(fric_ff), .time_step(dt_ff),
      .position_x(rsp.position_x), .position_y(rsp.position_y),
      .velocity_x(rsp.velocity_x), .velocity_y(rsp.velocity_y)
   );

   a_no_accept_while_out: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready) else $error("input taken while result pending");
   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.position_x))
      else $error("result changed while stalled");
   a_step_busy: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready && req.command == pmi_pkg::CMD_STEP |=> !req.ready)
      else $error("step did not start");
endmodule
`default_nettype wire
